// ===== rtl/core/rbs_pkg.sv =====
// ============================================================================
// rbs_pkg - shared definitions for the retry backoff scheduler
// Field widths, datapath widths, configuration register indexes and reset
// values used by the scheduler core.
// ============================================================================
package rbs_pkg;

    // Result and state widths.
    localparam int DELAY_WIDTH = 28;
    localparam int COUNT_WIDTH = 8;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int MS_W        = 20;
    localparam int RATIO_W     = 17;
    localparam int LIMIT_W     = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_MAX_RETRIES = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAXIMUM     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_DELAY   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PADDING     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_JITTER      = 3'd5;

    localparam logic [LIMIT_W-1:0] RST_MAX_RETRIES = 8'd3;
    localparam logic [MS_W-1:0]    RST_INITIAL     = 20'd1000;
    localparam logic [MS_W-1:0]    RST_MAXIMUM     = 20'd30000;
    localparam logic [RATIO_W-1:0] RATIO_ONE       = 17'd65536;

    // Input field widths.
    localparam int SERVER_W = 16;
    localparam int SAMPLE_W = 16;

    // Datapath widths: the largest base delay (server delay in ms plus
    // padding) fits in 27 bits; jitter at most doubles it.
    localparam int BASE_W      = 27;
    localparam int FIN_W       = BASE_W + 1;
    localparam int MR_W        = 32;
    localparam int PROD_W      = BASE_W + MR_W;
    localparam int ROUND_SHIFT = 31;
    localparam int SECOND_MS   = 1000;

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (ROUND_SHIFT - 1);

endpackage

// ===== rtl/core/retry_backoff_scheduler.sv =====
// ============================================================================
// retry_backoff_scheduler - capped exponential backoff with jitter
// Decides whether a failed request is retried and how long to wait first.
// ============================================================================
// Usage. Configuration registers are written over the cfg channel (index and
// data, one transfer per register); cfg_ready is always high, and writes are
// expected only while the block is idle. Each failure report arrives as one
// transfer on the in channel and yields exactly one result transfer on the
// out channel: scheduled, attempt, retry_limit and delay_ms.
// Processing, from the input transfer to the result transfer: a refused
// report goes straight to the output state. A scheduled one runs the
// doubling steps of the backoff sequencer (skipped when the server gave a
// delay), a load step, the shift-add jitter multiplier over the bits of
// the base delay (left at once when jitter is disabled or the sample is
// zero), a rounding step and the output state. The doubling and shift-add
// loops set the processing time. One report is processed at a time;
// in_ready is high only while the sequencer is idle.
// The result sits in an output register, so a new report may be taken while
// the receiver stalls; the next result then waits in the output state.
// Reset clears the retry count and the sequencer and returns the
// configuration registers to their defaults.
// ============================================================================
module retry_backoff_scheduler
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write channel.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rbs_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [rbs_pkg::CFG_DATA_W-1:0]        cfg_data,
    // Failure report channel.
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  retryable,
    input  logic                                  output_sent,
    input  logic [rbs_pkg::SERVER_W-1:0]          server_delay_s,
    input  logic signed [rbs_pkg::SAMPLE_W-1:0]   jitter_sample,
    // Retry decision channel.
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  scheduled,
    output logic [rbs_pkg::LIMIT_W-1:0]           attempt,
    output logic [rbs_pkg::LIMIT_W-1:0]           retry_limit,
    output logic [rbs_pkg::DELAY_WIDTH-1:0]       delay_ms
);

    localparam int CW = rbs_pkg::COUNT_WIDTH;
    localparam int BW = rbs_pkg::BASE_W;
    localparam int FW = rbs_pkg::FIN_W;
    localparam int PW = rbs_pkg::PROD_W;
    localparam int MW = rbs_pkg::MS_W;
    localparam int DW = rbs_pkg::DELAY_WIDTH;
    localparam int CMP_W = CW + rbs_pkg::LIMIT_W;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DOUBLE = 3'd1;
    localparam logic [2:0] ST_LOAD   = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_ADJ    = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    // Configuration registers.
    logic [rbs_pkg::LIMIT_W-1:0] max_retries_reg;
    logic [MW-1:0]               initial_reg;
    logic [MW-1:0]               maximum_reg;
    logic [MW-1:0]               min_delay_reg;
    logic [MW-1:0]               padding_reg;
    logic [rbs_pkg::RATIO_W-1:0] ratio_reg;

    // Sequencer and datapath.
    logic [2:0]               state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            iter_reg, iter_next;
    logic [BW-1:0]            base_reg, base_next;
    logic                     neg_reg, neg_next;
    logic [rbs_pkg::SAMPLE_W-1:0] mag_reg, mag_next;
    logic                     refused_reg, refused_next;
    logic [PW-1:0]            mcand_reg, mcand_next;
    logic [BW-1:0]            mulb_reg, mulb_next;
    logic [PW-1:0]            acc_reg, acc_next;
    logic [FW-1:0]            fin_reg, fin_next;

    // Output register.
    logic                          out_valid_reg, out_valid_next;
    logic                          scheduled_reg, scheduled_next;
    logic [rbs_pkg::LIMIT_W-1:0]   attempt_reg, attempt_next;
    logic [rbs_pkg::LIMIT_W-1:0]   retry_limit_reg, retry_limit_next;
    logic [DW-1:0]                 delay_reg, delay_next;

    // Combinational helpers.
    logic [MW-1:0]                 cap;
    logic [BW-1:0]                 cap_ext;
    logic                          refuse;
    logic [rbs_pkg::SAMPLE_W-1:0]  sample_bits;
    logic [rbs_pkg::MR_W-1:0]      mr;
    logic [PW-1:0]                 rounded;
    logic [FW-1:0]                 q;
    logic [FW-1:0]                 base_fin;
    logic [FW-1:0]                 floored;
    logic                          saturate;

    // The configuration port never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_retries_reg <= rbs_pkg::RST_MAX_RETRIES;
            initial_reg     <= rbs_pkg::RST_INITIAL;
            maximum_reg     <= rbs_pkg::RST_MAXIMUM;
            min_delay_reg   <= '0;
            padding_reg     <= '0;
            ratio_reg       <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rbs_pkg::REG_MAX_RETRIES: max_retries_reg <= cfg_data[rbs_pkg::LIMIT_W-1:0];
                rbs_pkg::REG_INITIAL:     initial_reg     <= cfg_data;
                rbs_pkg::REG_MAXIMUM:     maximum_reg     <= cfg_data;
                rbs_pkg::REG_MIN_DELAY:   min_delay_reg   <= cfg_data;
                rbs_pkg::REG_PADDING:     padding_reg     <= cfg_data;
                rbs_pkg::REG_JITTER:
                begin
                    // Ratios above one saturate to one.
                    if (cfg_data[rbs_pkg::RATIO_W-1:0] > rbs_pkg::RATIO_ONE)
                        ratio_reg <= rbs_pkg::RATIO_ONE;
                    else
                        ratio_reg <= cfg_data[rbs_pkg::RATIO_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // The effective cap is never below the initial backoff.
    assign cap     = (maximum_reg > initial_reg) ? maximum_reg : initial_reg;
    assign cap_ext = BW'(cap);

    // A retry is refused when it is not allowed, when the budget is spent or
    // when the counter cannot advance any further.
    assign refuse = !retryable || output_sent
                    || (CMP_W'(count_reg) >= CMP_W'(max_retries_reg))
                    || (count_reg == '1);

    assign sample_bits = jitter_sample;
    assign mr          = rbs_pkg::MR_W'(mag_reg) * rbs_pkg::MR_W'(ratio_reg);

    // Round half away from zero on the magnitude, then apply the sign.
    assign rounded  = acc_reg + rbs_pkg::ROUND_HALF;
    assign q        = FW'(rounded >> rbs_pkg::ROUND_SHIFT);
    assign base_fin = FW'(base_reg);

    assign floored  = (fin_reg < FW'(min_delay_reg)) ? FW'(min_delay_reg) : fin_reg;
    assign saturate = (floored >> DW) != '0;

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        iter_next        = iter_reg;
        base_next        = base_reg;
        neg_next         = neg_reg;
        mag_next         = mag_reg;
        refused_next     = refused_reg;
        mcand_next       = mcand_reg;
        mulb_next        = mulb_reg;
        acc_next         = acc_reg;
        fin_next         = fin_reg;
        out_valid_next   = out_valid_reg;
        scheduled_next   = scheduled_reg;
        attempt_next     = attempt_reg;
        retry_limit_next = retry_limit_reg;
        delay_next       = delay_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    neg_next = sample_bits[rbs_pkg::SAMPLE_W-1];
                    mag_next = sample_bits[rbs_pkg::SAMPLE_W-1] ? (~sample_bits + 1'b1)
                                                                : sample_bits;
                    if (refuse)
                    begin
                        refused_next = 1'b1;
                        state_next   = ST_FINISH;
                    end
                    else
                    begin
                        refused_next = 1'b0;
                        count_next   = count_reg + 1'b1;
                        // One doubling per earlier retry.
                        iter_next    = count_reg;
                        if (server_delay_s != '0)
                        begin
                            base_next  = BW'(server_delay_s) * BW'(rbs_pkg::SECOND_MS)
                                         + BW'(padding_reg);
                            state_next = ST_LOAD;
                        end
                        else
                        begin
                            base_next  = BW'(initial_reg);
                            state_next = ST_DOUBLE;
                        end
                    end
                end
            end

            ST_DOUBLE:
            begin
                if (iter_reg == '0)
                begin
                    base_next  = (base_reg < cap_ext) ? base_reg : cap_ext;
                    state_next = ST_LOAD;
                end
                else if (base_reg >= (cap_ext >> 1))
                begin
                    // Base at or above half the cap, rounded down: clamp and stop early.
                    base_next  = cap_ext;
                    state_next = ST_LOAD;
                end
                else if (base_reg == '0)
                begin
                    // A zero backoff below the cap stays zero however often
                    // it is doubled.
                    state_next = ST_LOAD;
                end
                else
                begin
                    base_next = base_reg << 1;
                    iter_next = iter_reg - 1'b1;
                end
            end

            ST_LOAD:
            begin
                // A zero amplitude leaves nothing to multiply.
                mcand_next = PW'(mr);
                acc_next   = '0;
                mulb_next  = (mr == '0) ? '0 : base_reg;
                state_next = ST_MUL;
            end

            ST_MUL:
            begin
                // Shift-add: one multiplier bit of the base delay per cycle.
                if (mulb_reg == '0)
                    state_next = ST_ADJ;
                else
                begin
                    if (mulb_reg[0])
                        acc_next = acc_reg + mcand_reg;
                    mcand_next = mcand_reg << 1;
                    mulb_next  = mulb_reg >> 1;
                end
            end

            ST_ADJ:
            begin
                // The correction never exceeds the delay, but clamp anyway.
                if (neg_reg)
                    fin_next = (q > base_fin) ? '0 : base_fin - q;
                else
                    fin_next = base_fin + q;
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    scheduled_next   = !refused_reg;
                    retry_limit_next = max_retries_reg;
                    if (refused_reg)
                    begin
                        attempt_next = '0;
                        delay_next   = '0;
                    end
                    else
                    begin
                        attempt_next = rbs_pkg::LIMIT_W'(count_reg);
                        delay_next   = saturate ? '1 : DW'(floored);
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iter_reg        <= iter_next;
        base_reg        <= base_next;
        neg_reg         <= neg_next;
        mag_reg         <= mag_next;
        refused_reg     <= refused_next;
        mcand_reg       <= mcand_next;
        mulb_reg        <= mulb_next;
        acc_reg         <= acc_next;
        fin_reg         <= fin_next;
        scheduled_reg   <= scheduled_next;
        attempt_reg     <= attempt_next;
        retry_limit_reg <= retry_limit_next;
        delay_reg       <= delay_next;
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign scheduled   = scheduled_reg;
    assign attempt     = attempt_reg;
    assign retry_limit = retry_limit_reg;
    assign delay_ms    = delay_reg;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb - self-checking testbench for the retry backoff scheduler
// Drives failure reports and register writes over valid/ready channels and
// predicts every retry decision with a cycle-free model of the scheduler.
// It opens with a directed table and then moves to randomised phases with
// fresh register settings, random idling on both sides, a long receiver
// hold-off and a final phase that runs the retry count up to its limit.
// ============================================================================
module tb;

    // Run control. The watchdog counts cycles without any transfer; its limit
    // leaves ample margin over the slowest correct decision and the long
    // receiver hold-off.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLDOFF_CYCLES  = 300;
    localparam int DRAIN_CYCLES    = 64;
    localparam int RANDOM_PHASES   = 20;
    localparam int ITEMS_PER_PHASE = 18;
    localparam int STEADY_PHASE    = 4;
    localparam int HOLDOFF_PHASE   = 8;

    // Indexes that map to no register; writes to them must be ignored.
    localparam logic [rbs_pkg::CFG_INDEX_W-1:0] UNMAPPED_REG_A = 3'd6;
    localparam logic [rbs_pkg::CFG_INDEX_W-1:0] UNMAPPED_REG_B = 3'd7;

    localparam logic [rbs_pkg::COUNT_WIDTH-1:0] COUNT_FULL    = '1;
    localparam logic [rbs_pkg::MS_W-1:0]        MS_FULL       = '1;
    localparam longint unsigned                 DELAY_CEILING =
        (64'd1 << rbs_pkg::DELAY_WIDTH) - 64'd1;

    typedef enum logic { ROW_CONFIG, ROW_REPORT } row_kind_t;

    // One failure report as it crosses the input channel.
    typedef struct packed {
        logic                                retryable;
        logic                                output_sent;
        logic [rbs_pkg::SERVER_W-1:0]        server_delay_s;
        logic signed [rbs_pkg::SAMPLE_W-1:0] jitter_sample;
    } report_t;

    // One retry decision as it crosses the output channel.
    typedef struct packed {
        logic                            scheduled;
        logic [rbs_pkg::LIMIT_W-1:0]     attempt;
        logic [rbs_pkg::LIMIT_W-1:0]     retry_limit;
        logic [rbs_pkg::DELAY_WIDTH-1:0] delay_ms;
    } decision_t;

    // A row of the directed table: either a register write or a report,
    // the latter optionally with its decision written out by hand.
    typedef struct packed {
        row_kind_t                       kind;
        logic [rbs_pkg::CFG_INDEX_W-1:0] index;
        logic [rbs_pkg::CFG_DATA_W-1:0]  data;
        report_t                         report;
        logic                            typed;
        decision_t                       want;
    } stim_row_t;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [rbs_pkg::CFG_INDEX_W-1:0]     cfg_index;
    logic [rbs_pkg::CFG_DATA_W-1:0]      cfg_data;
    logic                                in_valid;
    logic                                in_ready;
    logic                                retryable;
    logic                                output_sent;
    logic [rbs_pkg::SERVER_W-1:0]        server_delay_s;
    logic signed [rbs_pkg::SAMPLE_W-1:0] jitter_sample;
    logic                                out_valid;
    logic                                out_ready;
    logic                                scheduled;
    logic [rbs_pkg::LIMIT_W-1:0]         attempt;
    logic [rbs_pkg::LIMIT_W-1:0]         retry_limit;
    logic [rbs_pkg::DELAY_WIDTH-1:0]     delay_ms;

    // Hand-written expectation travelling alongside the offered report.
    logic                                offer_typed;
    decision_t                           offer_want;

    // The testbench's own copy of the scheduler's registers and retry count.
    logic [rbs_pkg::LIMIT_W-1:0]         limit_reg;
    logic [rbs_pkg::MS_W-1:0]            initial_reg;
    logic [rbs_pkg::MS_W-1:0]            maximum_reg;
    logic [rbs_pkg::MS_W-1:0]            floor_reg;
    logic [rbs_pkg::MS_W-1:0]            padding_reg;
    logic [rbs_pkg::RATIO_W-1:0]         ratio_reg;
    logic [rbs_pkg::COUNT_WIDTH-1:0]     retries_taken;

    decision_t                           pending_decisions[$];
    stim_row_t                           directed_rows[$];
    int                                  fail_count;
    bit                                  steady;
    bit                                  holdoff_request;

    retry_backoff_scheduler uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .retryable      (retryable),
        .output_sent    (output_sent),
        .server_delay_s (server_delay_s),
        .jitter_sample  (jitter_sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .scheduled      (scheduled),
        .attempt        (attempt),
        .retry_limit    (retry_limit),
        .delay_ms       (delay_ms)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Decision predictor. A refused report only echoes the budget and leaves
    // the count alone. An accepted one bumps the count, takes the server delay
    // in milliseconds plus padding, or else the initial backoff doubled once
    // per earlier retry under the effective cap, then applies jitter with
    // rounding half away from zero, the minimum floor and the width ceiling.
    // ------------------------------------------------------------------------
    function automatic decision_t predict_decision(report_t rep);
        decision_t       res;
        longint unsigned cap;
        longint unsigned wait_ms;
        longint unsigned sample_bits;
        longint unsigned magnitude;
        longint unsigned correction;
        int unsigned     step;
        logic            capped;
        res             = '0;
        res.retry_limit = limit_reg;
        if (!rep.retryable || rep.output_sent || retries_taken >= limit_reg
            || retries_taken == COUNT_FULL)
            return res;
        retries_taken = retries_taken + 1'b1;
        if (rep.server_delay_s != 0)
            wait_ms = {48'd0, rep.server_delay_s} * rbs_pkg::SECOND_MS + padding_reg;
        else
        begin
            cap     = 64'((maximum_reg > initial_reg) ? maximum_reg : initial_reg);
            wait_ms = 64'(initial_reg);
            capped  = 1'b0;
            // Once the value reaches half the cap, rounded down, the cap is taken.
            for (step = 1; step < retries_taken && !capped; step++)
            begin
                if (wait_ms >= cap / 2)
                begin
                    wait_ms = cap;
                    capped  = 1'b1;
                end
                else
                    wait_ms = wait_ms * 2;
            end
            if (wait_ms > cap)
                wait_ms = cap;
        end
        if (ratio_reg != 0 && wait_ms != 0)
        begin
            sample_bits = {48'd0, rep.jitter_sample};
            magnitude   = rep.jitter_sample[rbs_pkg::SAMPLE_W-1] ? 64'h10000 - sample_bits
                                                                 : sample_bits;
            // Q1.15 sample times Q1.16 ratio leaves 31 fraction bits.
            correction  = (wait_ms * magnitude * ratio_reg + (64'd1 << 30)) >> 31;
            if (rep.jitter_sample[rbs_pkg::SAMPLE_W-1])
                wait_ms = (correction > wait_ms) ? 64'd0 : wait_ms - correction;
            else
                wait_ms = wait_ms + correction;
        end
        if (wait_ms < floor_reg)
            wait_ms = 64'(floor_reg);
        if (wait_ms > DELAY_CEILING)
            wait_ms = DELAY_CEILING;
        res.scheduled = 1'b1;
        res.attempt   = retries_taken;
        res.delay_ms  = wait_ms[rbs_pkg::DELAY_WIDTH-1:0];
        return res;
    endfunction

    // Register write as the scheduler sees it; the ratio saturates at one.
    function automatic void apply_register_write(logic [rbs_pkg::CFG_INDEX_W-1:0] index,
                                                 logic [rbs_pkg::CFG_DATA_W-1:0] data);
        case (index)
            rbs_pkg::REG_MAX_RETRIES: limit_reg   = data[rbs_pkg::LIMIT_W-1:0];
            rbs_pkg::REG_INITIAL:     initial_reg = data[rbs_pkg::MS_W-1:0];
            rbs_pkg::REG_MAXIMUM:     maximum_reg = data[rbs_pkg::MS_W-1:0];
            rbs_pkg::REG_MIN_DELAY:   floor_reg   = data[rbs_pkg::MS_W-1:0];
            rbs_pkg::REG_PADDING:     padding_reg = data[rbs_pkg::MS_W-1:0];
            rbs_pkg::REG_JITTER:
                ratio_reg = (data[rbs_pkg::RATIO_W-1:0] > rbs_pkg::RATIO_ONE)
                            ? rbs_pkg::RATIO_ONE : data[rbs_pkg::RATIO_W-1:0];
            default:                  ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Transfer monitor. Everything is sampled at the rising edge, where the
    // testbench's inputs have been steady since the falling edge. A decision
    // transfer is checked before a same-edge report transfer is predicted,
    // since a report's decision never leaves at the edge that takes it in.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : transfer_monitor
        decision_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_decisions.size() == 0)
                begin
                    $display("%0t: decision transfer with none expected, actual %b/%0d/%0d/%0d",
                             $time, scheduled, attempt, retry_limit, delay_ms);
                    fail_count++;
                end
                else
                begin
                    want = pending_decisions.pop_front();
                    if (scheduled !== want.scheduled)
                    begin
                        $display("%0t: scheduled mismatch, expected %b, actual %b",
                                 $time, want.scheduled, scheduled);
                        fail_count++;
                    end
                    if (attempt !== want.attempt)
                    begin
                        $display("%0t: attempt mismatch, expected %0d, actual %0d",
                                 $time, want.attempt, attempt);
                        fail_count++;
                    end
                    if (retry_limit !== want.retry_limit)
                    begin
                        $display("%0t: retry_limit mismatch, expected %0d, actual %0d",
                                 $time, want.retry_limit, retry_limit);
                        fail_count++;
                    end
                    if (delay_ms !== want.delay_ms)
                    begin
                        $display("%0t: delay_ms mismatch, expected %0d, actual %0d",
                                 $time, want.delay_ms, delay_ms);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                apply_register_write(cfg_index, cfg_data);
            if (in_valid && in_ready)
            begin
                // The predictor runs for every report so that its retry count
                // keeps step, even where the row carries its own expectation.
                want = predict_decision({retryable, output_sent, server_delay_s,
                                         jitter_sample});
                pending_decisions.push_back(offer_typed ? offer_want : want);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. Stalls about one cycle in ten, never during the steady
    // phase, and once holds off for a long stretch so that the block backs up
    // and stops taking reports.
    // ------------------------------------------------------------------------
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES - 1) @(negedge clk);
                holdoff_request = 1'b0;
            end
            else if (!steady && $urandom_range(0, 99) < 10)
                out_ready <= 1'b0;
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog: the run is abandoned once nothing has moved for too long.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driving tasks. Inputs change only at the falling edge; a transfer is
    // recognised at the rising edge where valid and ready are both high.
    // ------------------------------------------------------------------------
    task automatic offer_report(report_t rep, logic typed, decision_t want);
        // Random sender gaps, one cycle at a time.
        while (!steady && $urandom_range(0, 99) < 10)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid       <= 1'b1;
        retryable      <= rep.retryable;
        output_sent    <= rep.output_sent;
        server_delay_s <= rep.server_delay_s;
        jitter_sample  <= rep.jitter_sample;
        offer_typed    <= typed;
        offer_want     <= want;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic write_register(logic [rbs_pkg::CFG_INDEX_W-1:0] index,
                                  logic [rbs_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // The sender stops and waits until every outstanding decision is back.
    // As each report yields a decision, the block is then idle.
    task automatic wait_for_decisions();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge clk);
    endtask

    task automatic note_write(logic [rbs_pkg::CFG_INDEX_W-1:0] index,
                              logic [rbs_pkg::CFG_DATA_W-1:0] data);
        stim_row_t row;
        row       = '0;
        row.kind  = ROW_CONFIG;
        row.index = index;
        row.data  = data;
        directed_rows.push_back(row);
    endtask

    task automatic note_report(report_t rep, logic typed, decision_t want);
        stim_row_t row;
        row        = '0;
        row.kind   = ROW_REPORT;
        row.report = rep;
        row.typed  = typed;
        row.want   = want;
        directed_rows.push_back(row);
    endtask

    // Millisecond register values: the extremes, short values that make the
    // doubling run long, and the full range.
    function automatic logic [rbs_pkg::MS_W-1:0] pick_ms();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return MS_FULL;
            2, 3:    return rbs_pkg::MS_W'($urandom_range(1, 64));
            4, 5:    return rbs_pkg::MS_W'($urandom_range(1, 5000));
            default: return rbs_pkg::MS_W'($urandom);
        endcase
    endfunction

    // Well-formed reports are retryable with nothing sent yet; the rest
    // are noise that is mostly refused.
    function automatic report_t random_report(bit well_formed);
        report_t rep;
        rep.retryable   = well_formed ? 1'b1 : 1'($urandom);
        rep.output_sent = well_formed ? 1'b0 : 1'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: rep.server_delay_s = '0;
            5:             rep.server_delay_s = '1;
            6:             rep.server_delay_s = rbs_pkg::SERVER_W'($urandom_range(1, 10));
            default:       rep.server_delay_s = rbs_pkg::SERVER_W'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       rep.jitter_sample = 16'sh8000;
            1:       rep.jitter_sample = 16'sh7FFF;
            2:       rep.jitter_sample = '0;
            default: rep.jitter_sample = rbs_pkg::SAMPLE_W'($urandom);
        endcase
        return rep;
    endfunction

    // A fresh setting for every register. The budget mostly leaves room for
    // a handful more retries, now and then none, and in the last phase the
    // whole count range so that the counter fills up.
    task automatic configure_phase(bit last_phase);
        logic [rbs_pkg::LIMIT_W-1:0] budget;
        int unsigned                 room;
        if (last_phase)
            budget = '1;
        else if ($urandom_range(0, 4) == 0)
            budget = rbs_pkg::LIMIT_W'($urandom_range(0, retries_taken));
        else
        begin
            room   = retries_taken + $urandom_range(1, 14);
            budget = (room > 255) ? 8'd255 : rbs_pkg::LIMIT_W'(room);
        end
        write_register(rbs_pkg::REG_MAX_RETRIES, {12'($urandom), budget});
        write_register(rbs_pkg::REG_INITIAL, pick_ms());
        write_register(rbs_pkg::REG_MAXIMUM, pick_ms());
        write_register(rbs_pkg::REG_MIN_DELAY, ($urandom_range(0, 2) == 0) ? pick_ms() : '0);
        write_register(rbs_pkg::REG_PADDING, pick_ms());
        case ($urandom_range(0, 5))
            0:       write_register(rbs_pkg::REG_JITTER, '0);
            1:       write_register(rbs_pkg::REG_JITTER,
                                    rbs_pkg::CFG_DATA_W'(rbs_pkg::RATIO_ONE));
            2:       write_register(rbs_pkg::REG_JITTER, rbs_pkg::CFG_DATA_W'($urandom));
            default: write_register(rbs_pkg::REG_JITTER,
                                    rbs_pkg::CFG_DATA_W'($urandom_range(1, 65536)));
        endcase
        if ($urandom_range(0, 3) == 0)
            write_register($urandom_range(0, 1) ? UNMAPPED_REG_A : UNMAPPED_REG_B,
                           rbs_pkg::CFG_DATA_W'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int phase;
        int item;

        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_valid        = 1'b0;
        retryable       = 1'b0;
        output_sent     = 1'b0;
        server_delay_s  = '0;
        jitter_sample   = '0;
        offer_typed     = 1'b0;
        offer_want      = '0;
        fail_count      = 0;
        steady          = 1'b0;
        holdoff_request = 1'b0;
        limit_reg       = rbs_pkg::RST_MAX_RETRIES;
        initial_reg     = rbs_pkg::RST_INITIAL;
        maximum_reg     = rbs_pkg::RST_MAXIMUM;
        floor_reg       = '0;
        padding_reg     = '0;
        ratio_reg       = '0;
        retries_taken   = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table. Reports are {retryable, output sent, server
        // delay, jitter sample}; typed decisions are {scheduled, attempt,
        // retry limit, delay}. Rows without one go to the predictor.
        // Reset defaults: budget 3, backoff 1000 ms capped at 30000 ms.
        note_report({1'b1, 1'b0, 16'd0, 16'h0000}, 1'b1, {1'b1, 8'd1, 8'd3, 28'd1000});
        note_report({1'b0, 1'b0, 16'd0, 16'h0000}, 1'b1, {1'b0, 8'd0, 8'd3, 28'd0});
        note_report({1'b1, 1'b1, 16'hFFFF, 16'h8000}, 1'b1, {1'b0, 8'd0, 8'd3, 28'd0});
        note_report({1'b1, 1'b0, 16'd0, 16'h7FFF}, 1'b1, {1'b1, 8'd2, 8'd3, 28'd2000});
        note_report({1'b1, 1'b0, 16'hFFFF, 16'h8000}, 1'b1,
                    {1'b1, 8'd3, 8'd3, 28'd65535000});
        // Budget used up.
        note_report({1'b1, 1'b0, 16'd1, 16'h0000}, 1'b1, {1'b0, 8'd0, 8'd3, 28'd0});
        // Upper data bits above the budget are dropped, a ratio above one
        // saturates, and the unmapped indexes change nothing.
        note_write(rbs_pkg::REG_MAX_RETRIES, 20'hFFF0C);
        note_write(rbs_pkg::REG_JITTER, 20'hFFFFF);
        note_write(rbs_pkg::REG_PADDING, MS_FULL);
        note_write(rbs_pkg::REG_MIN_DELAY, 20'd700);
        note_write(UNMAPPED_REG_A, 20'hAAAAA);
        note_write(UNMAPPED_REG_B, 20'h55555);
        // Largest server delay with full padding and full positive jitter.
        note_report({1'b1, 1'b0, 16'hFFFF, 16'h7FFF}, 1'b0, '0);
        // Full negative jitter cancels the delay, so the floor takes over.
        note_report({1'b1, 1'b0, 16'd1, 16'h8000}, 1'b1, {1'b1, 8'd5, 8'd12, 28'd700});
        // Doubling runs into the cap; a zero sample adds no jitter.
        note_report({1'b1, 1'b0, 16'd0, 16'h0000}, 1'b0, '0);
        // Maximum below initial: the initial backoff is the cap.
        note_write(rbs_pkg::REG_JITTER, '0);
        note_write(rbs_pkg::REG_INITIAL, MS_FULL);
        note_write(rbs_pkg::REG_MAXIMUM, '0);
        note_write(rbs_pkg::REG_MIN_DELAY, '0);
        note_report({1'b1, 1'b0, 16'd0, 16'h1234}, 1'b1,
                    {1'b1, 8'd7, 8'd12, 28'd1048575});
        note_write(rbs_pkg::REG_INITIAL, '0);
        note_report({1'b1, 1'b0, 16'd0, 16'h7FFF}, 1'b1, {1'b1, 8'd8, 8'd12, 28'd0});
        // A zero initial backoff under a cap of one: zero already reaches
        // half the cap, rounded down, so the cap is taken.
        note_write(rbs_pkg::REG_MAXIMUM, 20'd1);
        note_report({1'b1, 1'b0, 16'd0, 16'h0000}, 1'b1, {1'b1, 8'd9, 8'd12, 28'd1});
        // Long doubling from one millisecond, with tiny negative and half-scale positive jitter.
        note_write(rbs_pkg::REG_INITIAL, 20'd1);
        note_write(rbs_pkg::REG_MAXIMUM, MS_FULL);
        note_write(rbs_pkg::REG_JITTER, rbs_pkg::CFG_DATA_W'(rbs_pkg::RATIO_ONE));
        note_write(rbs_pkg::REG_PADDING, '0);
        note_report({1'b1, 1'b0, 16'd0, 16'hFFFF}, 1'b0, '0);
        note_report({1'b1, 1'b0, 16'd0, 16'h4000}, 1'b0, '0);
        note_report({1'b0, 1'b1, 16'd0, 16'h0000}, 1'b1, {1'b0, 8'd0, 8'd12, 28'd0});
        // A zero budget refuses everything.
        note_write(rbs_pkg::REG_MAX_RETRIES, '0);
        note_report({1'b1, 1'b0, 16'd0, 16'h0000}, 1'b1, {1'b0, 8'd0, 8'd0, 28'd0});

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CONFIG)
            begin
                wait_for_decisions();
                write_register(directed_rows[i].index, directed_rows[i].data);
            end
            else
                offer_report(directed_rows[i].report, directed_rows[i].typed,
                             directed_rows[i].want);
        end

        // Random phases. Each starts from an idle block with new settings.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_for_decisions();
            configure_phase(1'b0);
            steady = (phase == STEADY_PHASE);
            if (phase == HOLDOFF_PHASE)
                holdoff_request = 1'b1;
            for (item = 0; item < ITEMS_PER_PHASE; item++)
                offer_report(random_report($urandom_range(0, 9) < 7), 1'b0, '0);
        end
        steady = 1'b0;

        // Last phase: the full budget, then well-formed reports until the
        // retry counter is full, and a few more that it must refuse.
        wait_for_decisions();
        configure_phase(1'b1);
        while (retries_taken != COUNT_FULL)
            offer_report(random_report(1'b1), 1'b0, '0);
        repeat (6) offer_report(random_report(1'($urandom_range(0, 1))), 1'b0, '0);

        wait_for_decisions();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_decisions.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
